// ===== hdl/reorder_tracking_ack_generator_defines.svh =====
// ----------------------------------------------------------------------------
// Reorder tracking ack generator assertion macros
// Clocked assertion helpers shared by the RTL.
// ----------------------------------------------------------------------------
`ifndef REORDER_TRACKING_ACK_GENERATOR_DEFINES_SVH
`define REORDER_TRACKING_ACK_GENERATOR_DEFINES_SVH
`ifndef SYNTHESIS
`define RTAG_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("rtag assertion failed");
`define RTAG_NEVER(lbl, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("rtag assertion failed");
`else
`define RTAG_ASSERT(lbl, prop)
`define RTAG_NEVER(lbl, expr)
`endif
`endif

// ===== hdl/rtag_pkg.sv =====
// ----------------------------------------------------------------------------
// rtag_pkg
// Shared types and constants for the reorder tracking ack generator.
// ----------------------------------------------------------------------------
package rtag_pkg;

    localparam int OOO_DEPTH  = 64;
    localparam int CNT_W      = $clog2(OOO_DEPTH + 1);
    localparam int SEQ_W      = 32;
    localparam int TIME_W     = 48;
    localparam int PB_W       = 14;

    // gap / 1000 as (gap * ceil(2^38 / 1000)) >> 38, exact for 32-bit gaps
    localparam int RECIP_W    = 29;
    localparam int PROD_W     = SEQ_W + RECIP_W;
    localparam int DROP_SHIFT = 38;
    localparam int QUOT_W     = PROD_W - DROP_SHIFT;
    localparam logic [RECIP_W-1:0] DROP_RECIP = 29'd274877907;

    localparam logic [PB_W-1:0] PB_RESET  = 14'd4096;

    localparam logic REG_PACKET_BYTES = 1'b0;
    localparam logic REG_DUP_ACK      = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CMP,
        S_DECIDE,
        S_DRAIN,
        S_DIV,
        S_DROP
    } state_t;

    typedef enum logic [1:0] {
        EMIT_CUM,
        EMIT_PKT,
        EMIT_NACK
    } emit_kind_t;

    typedef struct packed {
        logic       load_in;
        logic       cmp;
        logic       set_point;
        logic       insert;
        logic       pop;
        logic       div_init;
        logic       div_step;
        logic       drop_upd;
        logic       emit;
        emit_kind_t emit_kind;
    } cmd_t;

    typedef struct packed {
        logic dup;
        logic dup_en;
        logic trim;
        logic inorder;
        logic count_zero;
        logic pop_ok;
    } status_t;

endpackage

// ===== hdl/rtag_ctrl.sv =====
// ----------------------------------------------------------------------------
// rtag_ctrl
// Sequencer: classify, drain, divide and emit for one packet at a time.
// ----------------------------------------------------------------------------
`include "reorder_tracking_ack_generator_defines.svh"

module rtag_ctrl
    import rtag_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start,
    input  status_t status,
    output cmd_t    cmd,
    output logic    busy
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_CMP;
                end
            end
            S_CMP:
            begin
                state_next = S_DECIDE;
            end
            S_DECIDE:
            begin
                if (status.dup || status.trim)
                begin
                    state_next = S_IDLE;
                end
                else if (status.inorder)
                begin
                    state_next = S_DRAIN;
                end
                else if (status.count_zero)
                begin
                    state_next = S_DIV;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_DRAIN:
            begin
                if (!status.pop_ok)
                begin
                    state_next = S_IDLE;
                end
            end
            S_DIV:
            begin
                state_next = S_DROP;
            end
            S_DROP:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd = '0;
        cmd.emit_kind = EMIT_CUM;
        unique case (state_reg)
            S_IDLE:
            begin
                cmd.load_in = start;
            end
            S_CMP:
            begin
                cmd.cmp = 1'b1;
            end
            S_DECIDE:
            begin
                if (status.dup)
                begin
                    cmd.emit = status.dup_en;
                end
                else if (status.trim)
                begin
                    cmd.emit      = 1'b1;
                    cmd.emit_kind = EMIT_NACK;
                end
                else if (status.inorder)
                begin
                    cmd.set_point = 1'b1;
                end
                else
                begin
                    cmd.insert = 1'b1;
                    if (status.count_zero)
                    begin
                        cmd.div_init = 1'b1;
                    end
                    else
                    begin
                        cmd.emit      = 1'b1;
                        cmd.emit_kind = EMIT_PKT;
                    end
                end
            end
            S_DRAIN:
            begin
                if (status.pop_ok)
                begin
                    cmd.pop = 1'b1;
                end
                else
                begin
                    cmd.emit = 1'b1;
                end
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
            end
            S_DROP:
            begin
                cmd.drop_upd  = 1'b1;
                cmd.emit      = 1'b1;
                cmd.emit_kind = EMIT_PKT;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    assign busy = (state_reg != S_IDLE);

    `RTAG_ASSERT(a_accept_busy, (start && !busy) |=> busy)
    `RTAG_ASSERT(a_emit_idle, cmd.emit |=> !busy)
    `RTAG_NEVER(a_pop_emit, cmd.pop && cmd.emit)
    `RTAG_ASSERT(a_drop_after_div, cmd.drop_upd |-> $past(cmd.div_step))

endmodule

// ===== hdl/rtag_dp.sv =====
// ----------------------------------------------------------------------------
// rtag_dp
// Datapath: input latch, cumulative point, sorted cell chain, drop divider,
// config registers and result registers.
// ----------------------------------------------------------------------------
`include "reorder_tracking_ack_generator_defines.svh"

module rtag_dp
    import rtag_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic              cfg_addr,
    input  logic [PB_W-1:0]   cfg_data,
    input  logic [SEQ_W-1:0]  seq_num,
    input  logic              trimmed,
    input  logic              ce_mark,
    input  logic [TIME_W-1:0] send_time,
    input  cmd_t              cmd,
    output status_t           status,
    output logic              done,
    output logic              is_nack,
    output logic [SEQ_W-1:0]  ack_seq,
    output logic [SEQ_W-1:0]  ack_num,
    output logic              ce_echo,
    output logic [TIME_W-1:0] echo_time,
    output logic              list_overflow,
    output logic [SEQ_W-1:0]  drop_estimate
);

    logic [PB_W-1:0]      pb_reg;
    logic                 dupen_reg;
    logic [SEQ_W-1:0]     seq_reg;
    logic                 trim_reg;
    logic                 ce_reg;
    logic [TIME_W-1:0]    ts_reg;
    logic [SEQ_W-1:0]     point_reg;
    logic [SEQ_W-1:0]     drop_reg;
    logic [CNT_W-1:0]     count_reg;
    logic [SEQ_W-1:0]     cell_reg  [OOO_DEPTH];
    logic [SEQ_W-1:0]     cell_next [OOO_DEPTH];
    logic [OOO_DEPTH-1:0] eq_reg;
    logic [OOO_DEPTH-1:0] lt_reg;
    logic                 ovf_reg;
    logic [SEQ_W-1:0]     dvd_reg;
    logic                 done_reg;

    logic [SEQ_W-1:0]  pb32;
    logic [SEQ_W-1:0]  pkt_end;
    logic [SEQ_W-1:0]  point_inc;
    logic              full;
    logic [PROD_W-1:0] quot_prod;
    logic [SEQ_W:0]    drop_sum;
    logic [SEQ_W-1:0]  drop_sat;

    assign pb32      = {{(SEQ_W-PB_W){1'b0}}, pb_reg};
    assign pkt_end   = seq_reg + pb32 - 32'd1;
    assign point_inc = point_reg + 32'd1;
    assign full      = (count_reg == CNT_W'(OOO_DEPTH));
    assign quot_prod = {{RECIP_W{1'b0}}, dvd_reg} * {{SEQ_W{1'b0}}, DROP_RECIP};
    assign drop_sum  = {1'b0, drop_reg} + {1'b0, dvd_reg} + 33'd1;
    assign drop_sat  = drop_sum[SEQ_W] ? '1 : drop_sum[SEQ_W-1:0];

    assign status.dup        = (seq_reg <= point_reg) || (|eq_reg);
    assign status.dup_en     = dupen_reg;
    assign status.trim       = trim_reg;
    assign status.inorder    = (seq_reg == point_inc);
    assign status.count_zero = (count_reg == '0);
    assign status.pop_ok     = (count_reg != '0) && (cell_reg[0] == point_inc);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pb_reg    <= PB_RESET;
            dupen_reg <= 1'b1;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                REG_PACKET_BYTES: pb_reg    <= cfg_data;
                REG_DUP_ACK:      dupen_reg <= cfg_data[0];
                default:          pb_reg    <= pb_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            seq_reg  <= seq_num;
            trim_reg <= trimmed;
            ce_reg   <= ce_mark;
            ts_reg   <= send_time;
        end
    end

    genvar gi;
    generate
        for (gi = 0; gi < OOO_DEPTH; gi++)
        begin : g_cell
            logic valid;
            logic prev_lt;
            assign valid   = (CNT_W'(gi) < count_reg);
            if (gi == 0)
            begin : g_first
                assign prev_lt = 1'b1;
            end
            else
            begin : g_rest
                assign prev_lt = lt_reg[gi-1];
            end

            always_ff @(posedge clk)
            begin
                if (cmd.cmp)
                begin
                    eq_reg[gi] <= valid && (cell_reg[gi] == seq_reg);
                    lt_reg[gi] <= valid && (cell_reg[gi] < seq_reg);
                end
            end

            always_comb
            begin
                cell_next[gi] = cell_reg[gi];
                if (cmd.insert && !full && !lt_reg[gi] && (CNT_W'(gi) <= count_reg))
                begin
                    if (gi == 0 || prev_lt)
                    begin
                        cell_next[gi] = seq_reg;
                    end
                    else
                    begin
                        cell_next[gi] = cell_reg[(gi == 0) ? 0 : gi-1];
                    end
                end
                else if (cmd.pop && gi < OOO_DEPTH-1)
                begin
                    cell_next[gi] = cell_reg[(gi < OOO_DEPTH-1) ? gi+1 : gi];
                end
            end

            always_ff @(posedge clk)
            begin
                cell_reg[gi] <= cell_next[gi];
            end
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            point_reg <= '0;
            count_reg <= '0;
            drop_reg  <= '0;
        end
        else
        begin
            if (cmd.set_point)
            begin
                point_reg <= pkt_end;
            end
            else if (cmd.pop)
            begin
                point_reg <= point_reg + pb32;
            end
            if (cmd.insert && !full)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            else if (cmd.pop)
            begin
                count_reg <= count_reg - CNT_W'(1);
            end
            if (cmd.drop_upd)
            begin
                drop_reg <= drop_sat;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            ovf_reg <= 1'b0;
        end
        else if (cmd.insert)
        begin
            ovf_reg <= full;
        end
        if (cmd.div_init)
        begin
            dvd_reg <= seq_reg - point_inc;
        end
        else if (cmd.div_step)
        begin
            dvd_reg <= {{(SEQ_W-QUOT_W){1'b0}}, quot_prod[PROD_W-1:DROP_SHIFT]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= cmd.emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            ce_echo       <= ce_reg;
            echo_time     <= ts_reg;
            list_overflow <= cmd.insert ? full : ovf_reg;
            drop_estimate <= cmd.drop_upd ? drop_sat : drop_reg;
            case (cmd.emit_kind)
                EMIT_PKT:
                begin
                    is_nack <= 1'b0;
                    ack_seq <= seq_reg;
                    ack_num <= pkt_end;
                end
                EMIT_NACK:
                begin
                    is_nack <= 1'b1;
                    ack_seq <= seq_reg;
                    ack_num <= pkt_end;
                end
                default:
                begin
                    is_nack <= 1'b0;
                    ack_seq <= 32'd1;
                    ack_num <= point_reg;
                end
            endcase
        end
    end

    assign done = done_reg;

    `RTAG_NEVER(a_count_range, count_reg > CNT_W'(OOO_DEPTH))
    `RTAG_NEVER(a_pop_empty, cmd.pop && (count_reg == '0))
    `RTAG_ASSERT(a_insert_grows, (cmd.insert && !full) |=> (count_reg == $past(count_reg) + 1'b1))

endmodule

// ===== hdl/reorder_tracking_ack_generator.sv =====
// ----------------------------------------------------------------------------
// reorder_tracking_ack_generator
// Receive-side ack/nack generator with a sorted out-of-order list.
// ----------------------------------------------------------------------------
// A packet word is taken when start is high and busy is low. At most one
// result word follows, shown for one cycle with done high; the receiver
// cannot stall it. Configuration: cfg_we, cfg_addr (0 packet_bytes,
// 1 dup_ack_enable), cfg_data; the user must see that these are written
// only while idle; the block does not enforce it. After CMP, DECIDE emits
// the result for a duplicate, nack or future packet with a non-empty list;
// an in-order packet drains list entries in DRAIN (one pop per cycle in the
// cell chain) and then emits; the first future packet after an empty list
// passes DIV (gap scaled by a reciprocal multiply) and DROP (a saturating
// add), which emits. One packet at a time: the next can be taken at the edge
// that ends the done cycle, or after DECIDE if a duplicate gives no result.
// Reset clears the cumulative point, list count, drop estimate and loads
// the register defaults; list cells need no clearing.
// ----------------------------------------------------------------------------
module reorder_tracking_ack_generator
    import rtag_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic              cfg_addr,
    input  logic [PB_W-1:0]   cfg_data,
    input  logic              start,
    output logic              busy,
    input  logic [SEQ_W-1:0]  seq_num,
    input  logic              trimmed,
    input  logic              ce_mark,
    input  logic [TIME_W-1:0] send_time,
    output logic              done,
    output logic              is_nack,
    output logic [SEQ_W-1:0]  ack_seq,
    output logic [SEQ_W-1:0]  ack_num,
    output logic              ce_echo,
    output logic [TIME_W-1:0] echo_time,
    output logic              list_overflow,
    output logic [SEQ_W-1:0]  drop_estimate
);

    cmd_t    cmd;
    status_t status;

    rtag_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy)
    );

    rtag_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_data      (cfg_data),
        .seq_num       (seq_num),
        .trimmed       (trimmed),
        .ce_mark       (ce_mark),
        .send_time     (send_time),
        .cmd           (cmd),
        .status        (status),
        .done          (done),
        .is_nack       (is_nack),
        .ack_seq       (ack_seq),
        .ack_num       (ack_num),
        .ce_echo       (ce_echo),
        .echo_time     (echo_time),
        .list_overflow (list_overflow),
        .drop_estimate (drop_estimate)
    );

endmodule
